>>> sv/can_id_range_filter_bank_packer_core_assert.svh
// Assertion macros for the CAN identifier range filter bank packer.
`ifndef CAN_ID_RANGE_FILTER_BANK_PACKER_CORE_ASSERT_SVH
`define CAN_ID_RANGE_FILTER_BANK_PACKER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CIDRFBP_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("same-cycle check failed");
`define CIDRFBP_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("next-cycle check failed");
`else
`define CIDRFBP_ASSERT_IMP(lbl, pre, post)
`define CIDRFBP_ASSERT_NXT(lbl, pre, post)
`endif
`endif

>>> sv/cidrfbp_pkg.sv
// Types and constants shared by the filter bank packer modules.
`timescale 1ns / 1ps
package cidrfbp_pkg;

	localparam int ID_W        = 29;
	localparam int SZ_W        = 30;
	localparam int STD_ID_BITS = 11;
	localparam int EXT_ID_BITS = 29;

	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_FINISH = 2'd1;
	localparam logic [1:0] REQ_START  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [3:0] MAX_WRITES = 4'd14;

	localparam logic KIND_BANK   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [2:0] {
		OP_STD_ID,
		OP_STD_MASK,
		OP_EXT_ID,
		OP_EXT_MASK,
		OP_FLUSH_SL,
		OP_FLUSH_SM,
		OP_FLUSH_EL,
		OP_CLEAR
	} pack_op_t;

	typedef struct packed {
		logic            vld;
		pack_op_t        op;
		logic [ID_W-1:0] id;
		logic [ID_W-1:0] mask;
	} pack_cmd_t;

	typedef struct packed {
		logic        wr_req;
		logic [31:0] w1;
		logic [31:0] w2;
		logic        wide;
		logic        mmode;
	} pack_rsp_t;

	typedef struct packed {
		logic sl;
		logic sm;
		logic el;
	} pack_pend_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOWBIT,
		S_CHECK,
		S_FIN_SL,
		S_FIN_SM,
		S_FIN_EL,
		S_STATUS
	} fsm_t;

endpackage

>>> sv/cidrfbp_pack.sv
// Pending list and mask groups, with bank word formatting.
`timescale 1ns / 1ps
module cidrfbp_pack (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cidrfbp_pkg::pack_cmd_t  cmd,
	output cidrfbp_pkg::pack_rsp_t  rsp,
	output cidrfbp_pkg::pack_pend_t pend
);

	logic [10:0] std_ids_q [4];
	logic [21:0] sm_entries_q [2];
	logic [28:0] ext_ids_q [2];
	logic [1:0]  std_cnt_q;
	logic        sm_cnt_q;
	logic        ext_cnt_q;

	logic [10:0] std_id;
	logic [10:0] blk_msk;
	logic [21:0] entry;

	assign std_id  = cmd.id[10:0];
	assign blk_msk = cmd.mask[10:0];
	assign entry   = {blk_msk, std_id};

	assign pend.sl = (std_cnt_q != 2'd0);
	assign pend.sm = sm_cnt_q;
	assign pend.el = ext_cnt_q;

	always_comb begin
		rsp = '0;
		unique case (cmd.op)
			cidrfbp_pkg::OP_STD_ID: begin
				rsp.wr_req = (std_cnt_q == 2'd3);
				rsp.w1     = {std_ids_q[1], 5'b0, std_ids_q[0], 5'b0};
				rsp.w2     = {std_id, 5'b0, std_ids_q[2], 5'b0};
			end
			cidrfbp_pkg::OP_STD_MASK: begin
				rsp.wr_req = sm_cnt_q;
				rsp.w1     = {sm_entries_q[0][21:11], 5'b0, sm_entries_q[0][10:0], 5'b0};
				rsp.w2     = {blk_msk, 5'b0, std_id, 5'b0};
				rsp.mmode  = 1'b1;
			end
			cidrfbp_pkg::OP_EXT_ID: begin
				rsp.wr_req = ext_cnt_q;
				rsp.w1     = {ext_ids_q[0], 3'b0};
				rsp.w2     = {cmd.id, 3'b0};
				rsp.wide   = 1'b1;
			end
			cidrfbp_pkg::OP_EXT_MASK: begin
				rsp.wr_req = 1'b1;
				rsp.w1     = {cmd.id, 3'b0};
				rsp.w2     = {cmd.mask, 3'b0};
				rsp.wide   = 1'b1;
				rsp.mmode  = 1'b1;
			end
			cidrfbp_pkg::OP_FLUSH_SL: begin
				rsp.wr_req = 1'b1;
				rsp.w1     = {std_ids_q[1], 5'b0, std_ids_q[0], 5'b0};
				rsp.w2     = {std_ids_q[3], 5'b0, std_ids_q[2], 5'b0};
			end
			cidrfbp_pkg::OP_FLUSH_SM: begin
				rsp.wr_req = 1'b1;
				rsp.w1     = {sm_entries_q[0][21:11], 5'b0, sm_entries_q[0][10:0], 5'b0};
				rsp.w2     = {sm_entries_q[1][21:11], 5'b0, sm_entries_q[1][10:0], 5'b0};
				rsp.mmode  = 1'b1;
			end
			cidrfbp_pkg::OP_FLUSH_EL: begin
				rsp.wr_req = 1'b1;
				rsp.w1     = {ext_ids_q[0], 3'b0};
				rsp.w2     = {ext_ids_q[1], 3'b0};
				rsp.wide   = 1'b1;
			end
			cidrfbp_pkg::OP_CLEAR: begin
				rsp.wr_req = 1'b0;
			end
			default: begin
				rsp.wr_req = 1'b0;
			end
		endcase
		rsp.wr_req = rsp.wr_req & cmd.vld;
	end

	// entry stores: a new group is padded with its first entry
	always_ff @(posedge clk) begin
		if (cmd.vld) begin
			unique case (cmd.op)
				cidrfbp_pkg::OP_STD_ID: begin
					if (std_cnt_q == 2'd0) begin
						std_ids_q[0] <= std_id;
						std_ids_q[1] <= std_id;
						std_ids_q[2] <= std_id;
						std_ids_q[3] <= std_id;
					end else begin
						std_ids_q[std_cnt_q] <= std_id;
					end
				end
				cidrfbp_pkg::OP_STD_MASK: begin
					if (!sm_cnt_q) begin
						sm_entries_q[0] <= entry;
						sm_entries_q[1] <= entry;
					end else begin
						sm_entries_q[1] <= entry;
					end
				end
				cidrfbp_pkg::OP_EXT_ID: begin
					if (!ext_cnt_q) begin
						ext_ids_q[0] <= cmd.id;
						ext_ids_q[1] <= cmd.id;
					end else begin
						ext_ids_q[1] <= cmd.id;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			std_cnt_q <= 2'd0;
			sm_cnt_q  <= 1'b0;
			ext_cnt_q <= 1'b0;
		end else if (cmd.vld) begin
			unique case (cmd.op)
				cidrfbp_pkg::OP_STD_ID:   std_cnt_q <= std_cnt_q + 2'd1;
				cidrfbp_pkg::OP_STD_MASK: sm_cnt_q  <= ~sm_cnt_q;
				cidrfbp_pkg::OP_EXT_ID:   ext_cnt_q <= ~ext_cnt_q;
				cidrfbp_pkg::OP_EXT_MASK: begin
				end
				cidrfbp_pkg::OP_FLUSH_SL: std_cnt_q <= 2'd0;
				cidrfbp_pkg::OP_FLUSH_SM: sm_cnt_q  <= 1'b0;
				cidrfbp_pkg::OP_FLUSH_EL: ext_cnt_q <= 1'b0;
				cidrfbp_pkg::OP_CLEAR: begin
					std_cnt_q <= 2'd0;
					sm_cnt_q  <= 1'b0;
					ext_cnt_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> sv/can_id_range_filter_bank_packer_core.sv
// Top level: CAN identifier range to prefix block decomposition and bank packing.
// One request at a time; ready only while idle. Add: latch the request, then per
// prefix block a lowest-set-bit step and a fit check, halving the block size until
// it fits; a held result stalls the sequence. Finish: flush the pending standard list,
// standard mask and extended list groups in turn; start: clear the packer and bank pointer. Status transaction follows.
// arst_n clears the sequencer, counts, bank pointer and output valid; stores hold data.
`timescale 1ns / 1ps
module can_id_range_filter_bank_packer_core #(
	parameter int NUM_BANKS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  req_type,
	input  logic        is_extended,
	input  logic [28:0] range_begin,
	input  logic [28:0] range_end,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        result_kind,
	output logic [3:0]  bank_index,
	output logic [31:0] filter_word_one,
	output logic [31:0] filter_word_two,
	output logic        wide_scale,
	output logic        mask_mode,
	output logic [1:0]  status,
	output logic        last
);

`include "can_id_range_filter_bank_packer_core_assert.svh"

	localparam int ZW = cidrfbp_pkg::SZ_W;
	localparam int IW = cidrfbp_pkg::ID_W;

	cidrfbp_pkg::fsm_t state_q, state_d;

	logic [ZW-1:0] lo_q, lo_d;
	logic [IW-1:0] hi_q, hi_d;
	logic [ZW-1:0] sz_q, sz_d;
	logic          ext_q, ext_d;
	logic [1:0]    st_q, st_d;
	logic [3:0]    wr_cnt_q, wr_cnt_d;
	logic [3:0]    next_bank_q, next_bank_d;

	logic          res_valid_q;
	logic          kind_q;
	logic [3:0]    bank_q;
	logic [31:0]   w1_q, w2_q;
	logic          wide_q, mmode_q;
	logic [1:0]    status_q;
	logic          last_q;

	cidrfbp_pkg::pack_cmd_t  cmd;
	cidrfbp_pkg::pack_rsp_t  rsp;
	cidrfbp_pkg::pack_pend_t pend;

	logic          accept;
	logic          out_free;
	logic          bank_full;
	logic          wr_go, wr_fail;
	logic          out_load_bank, out_load_status;
	logic [IW-1:0] lo_in, hi_in, maxid_in, maxid;
	logic          range_bad;
	logic [ZW-1:0] lowbit, sum, hi1, szm1;
	logic          fits, last_blk;
	logic [IW-1:0] mask_blk;

	cidrfbp_pack u_pack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp),
		.pend   (pend)
	);

	assign req_ready = (state_q == cidrfbp_pkg::S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !res_valid_q || res_ready;
	assign bank_full = (next_bank_q >= 4'(NUM_BANKS)) || (wr_cnt_q >= cidrfbp_pkg::MAX_WRITES);

	assign lo_in     = (range_begin > range_end) ? range_end : range_begin;
	assign hi_in     = (range_begin > range_end) ? range_begin : range_end;
	assign maxid_in  = is_extended ? {IW{1'b1}} : IW'({cidrfbp_pkg::STD_ID_BITS{1'b1}});
	assign maxid     = ext_q ? {IW{1'b1}} : IW'({cidrfbp_pkg::STD_ID_BITS{1'b1}});
	assign range_bad = (hi_in > maxid_in);

	// block arithmetic
	assign lowbit   = lo_q & (~lo_q + ZW'(1));
	assign sum      = lo_q + sz_q;
	assign hi1      = {1'b0, hi_q} + ZW'(1);
	assign fits     = (sum <= hi1);
	assign last_blk = (sum == hi1);
	assign szm1     = sz_q - ZW'(1);
	assign mask_blk = maxid & ~szm1[IW-1:0];

	assign wr_go   = rsp.wr_req && !bank_full;
	assign wr_fail = rsp.wr_req && bank_full;

	always_comb begin
		cmd      = '0;
		cmd.op   = cidrfbp_pkg::OP_CLEAR;
		cmd.id   = lo_q[IW-1:0];
		cmd.mask = mask_blk;
		unique case (state_q)
			cidrfbp_pkg::S_IDLE: begin
				cmd.vld = accept && (req_type == cidrfbp_pkg::REQ_START);
			end
			cidrfbp_pkg::S_CHECK: begin
				cmd.vld = fits && out_free;
				if (sz_q == ZW'(1))
					cmd.op = ext_q ? cidrfbp_pkg::OP_EXT_ID : cidrfbp_pkg::OP_STD_ID;
				else
					cmd.op = ext_q ? cidrfbp_pkg::OP_EXT_MASK : cidrfbp_pkg::OP_STD_MASK;
			end
			cidrfbp_pkg::S_FIN_SL: begin
				cmd.vld = pend.sl && out_free;
				cmd.op  = cidrfbp_pkg::OP_FLUSH_SL;
			end
			cidrfbp_pkg::S_FIN_SM: begin
				cmd.vld = pend.sm && out_free;
				cmd.op  = cidrfbp_pkg::OP_FLUSH_SM;
			end
			cidrfbp_pkg::S_FIN_EL: begin
				cmd.vld = pend.el && out_free;
				cmd.op  = cidrfbp_pkg::OP_FLUSH_EL;
			end
			default: begin
				cmd.vld = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d         = state_q;
		lo_d            = lo_q;
		hi_d            = hi_q;
		sz_d            = sz_q;
		ext_d           = ext_q;
		st_d            = st_q;
		wr_cnt_d        = wr_cnt_q;
		next_bank_d     = next_bank_q;
		out_load_status = 1'b0;
		out_load_bank   = cmd.vld && wr_go;
		unique case (state_q)
			cidrfbp_pkg::S_IDLE: begin
				if (accept) begin
					lo_d     = {1'b0, lo_in};
					hi_d     = hi_in;
					ext_d    = is_extended;
					st_d     = cidrfbp_pkg::ST_OK;
					wr_cnt_d = 4'd0;
					unique case (req_type)
						cidrfbp_pkg::REQ_ADD: begin
							if (range_bad) begin
								st_d    = cidrfbp_pkg::ST_RANGE;
								state_d = cidrfbp_pkg::S_STATUS;
							end else begin
								state_d = cidrfbp_pkg::S_LOWBIT;
							end
						end
						cidrfbp_pkg::REQ_FINISH: state_d = cidrfbp_pkg::S_FIN_SL;
						cidrfbp_pkg::REQ_START: begin
							next_bank_d = 4'd0;
							state_d     = cidrfbp_pkg::S_STATUS;
						end
						default: state_d = cidrfbp_pkg::S_STATUS;
					endcase
				end
			end
			cidrfbp_pkg::S_LOWBIT: begin
				if (lo_q == '0)
					sz_d = ext_q ? (ZW'(1) << cidrfbp_pkg::EXT_ID_BITS)
						: (ZW'(1) << cidrfbp_pkg::STD_ID_BITS);
				else
					sz_d = lowbit;
				state_d = cidrfbp_pkg::S_CHECK;
			end
			cidrfbp_pkg::S_CHECK: begin
				if (!fits) begin
					sz_d = sz_q >> 1;
				end else if (out_free) begin
					if (wr_fail) begin
						st_d    = cidrfbp_pkg::ST_FULL;
						state_d = cidrfbp_pkg::S_STATUS;
					end else begin
						lo_d    = sum;
						state_d = last_blk ? cidrfbp_pkg::S_STATUS : cidrfbp_pkg::S_LOWBIT;
					end
				end
			end
			cidrfbp_pkg::S_FIN_SL: begin
				if (!pend.sl) begin
					state_d = cidrfbp_pkg::S_FIN_SM;
				end else if (out_free) begin
					if (wr_fail) begin
						st_d    = cidrfbp_pkg::ST_FULL;
						state_d = cidrfbp_pkg::S_STATUS;
					end else begin
						state_d = cidrfbp_pkg::S_FIN_SM;
					end
				end
			end
			cidrfbp_pkg::S_FIN_SM: begin
				if (!pend.sm) begin
					state_d = cidrfbp_pkg::S_FIN_EL;
				end else if (out_free) begin
					if (wr_fail) begin
						st_d    = cidrfbp_pkg::ST_FULL;
						state_d = cidrfbp_pkg::S_STATUS;
					end else begin
						state_d = cidrfbp_pkg::S_FIN_EL;
					end
				end
			end
			cidrfbp_pkg::S_FIN_EL: begin
				if (!pend.el) begin
					state_d = cidrfbp_pkg::S_STATUS;
				end else if (out_free) begin
					if (wr_fail)
						st_d = cidrfbp_pkg::ST_FULL;
					state_d = cidrfbp_pkg::S_STATUS;
				end
			end
			cidrfbp_pkg::S_STATUS: begin
				if (out_free) begin
					out_load_status = 1'b1;
					state_d         = cidrfbp_pkg::S_IDLE;
				end
			end
			default: state_d = cidrfbp_pkg::S_IDLE;
		endcase
		if (out_load_bank) begin
			next_bank_d = next_bank_q + 4'd1;
			wr_cnt_d    = wr_cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cidrfbp_pkg::S_IDLE;
			next_bank_q <= 4'd0;
			wr_cnt_q    <= 4'd0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			next_bank_q <= next_bank_d;
			wr_cnt_q    <= wr_cnt_d;
			if (out_load_bank || out_load_status)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		sz_q  <= sz_d;
		ext_q <= ext_d;
		st_q  <= st_d;
		if (out_load_bank) begin
			kind_q   <= cidrfbp_pkg::KIND_BANK;
			bank_q   <= next_bank_q;
			w1_q     <= rsp.w1;
			w2_q     <= rsp.w2;
			wide_q   <= rsp.wide;
			mmode_q  <= rsp.mmode;
			status_q <= cidrfbp_pkg::ST_OK;
			last_q   <= 1'b0;
		end else if (out_load_status) begin
			kind_q   <= cidrfbp_pkg::KIND_STATUS;
			bank_q   <= 4'd0;
			w1_q     <= 32'd0;
			w2_q     <= 32'd0;
			wide_q   <= 1'b0;
			mmode_q  <= 1'b0;
			status_q <= st_q;
			last_q   <= 1'b1;
		end
	end

	assign res_valid       = res_valid_q;
	assign result_kind     = kind_q;
	assign bank_index      = bank_q;
	assign filter_word_one = w1_q;
	assign filter_word_two = w2_q;
	assign wide_scale      = wide_q;
	assign mask_mode       = mmode_q;
	assign status          = status_q;
	assign last            = last_q;

	`CIDRFBP_ASSERT_IMP(a_bank_bound, 1'b1, next_bank_q <= 4'(NUM_BANKS))
	`CIDRFBP_ASSERT_IMP(a_write_cap, 1'b1, wr_cnt_q <= cidrfbp_pkg::MAX_WRITES)
	`CIDRFBP_ASSERT_IMP(a_load_free, out_load_bank || out_load_status, !res_valid_q || res_ready)
	`CIDRFBP_ASSERT_IMP(a_single_load, out_load_bank, !out_load_status)
	`CIDRFBP_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

endmodule

>>> sim/filter_bank_write_checker.sv
// Checker for the filter bank packer: predicts bank writes and status transactions and compares.
`timescale 1ns / 1ps
module filter_bank_write_checker #(
	parameter int NUM_BANKS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  logic [1:0]  req_type,
	input  logic        is_extended,
	input  logic [28:0] range_begin,
	input  logic [28:0] range_end,
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic        result_kind,
	input  logic [3:0]  bank_index,
	input  logic [31:0] filter_word_one,
	input  logic [31:0] filter_word_two,
	input  logic        wide_scale,
	input  logic        mask_mode,
	input  logic [1:0]  status,
	input  logic        last,
	output int          mismatches,
	output int          expected_count
);

	typedef struct packed {
		logic        kind;
		logic [3:0]  bank;
		logic [31:0] word_one;
		logic [31:0] word_two;
		logic        wide;
		logic        mmode;
		logic [1:0]  st;
		logic        is_last;
	} bank_result_t;

	logic [10:0]  std_ids [4];
	logic [21:0]  sm_entries [2];
	logic [28:0]  ext_ids [2];
	int           std_id_cnt;
	int           sm_cnt;
	int           ext_id_cnt;
	logic [3:0]   bank_ptr;
	int           writes_in_req;
	bank_result_t predicted_results [$];

	function automatic void clear_state();
		foreach (std_ids[i]) std_ids[i] = '0;
		foreach (sm_entries[i]) sm_entries[i] = '0;
		foreach (ext_ids[i]) ext_ids[i] = '0;
		std_id_cnt = 0;
		sm_cnt     = 0;
		ext_id_cnt = 0;
		bank_ptr   = '0;
	endfunction

	function automatic logic [1:0] emit_bank(input logic [31:0] w1, input logic [31:0] w2,
			input logic wide, input logic mmode);
		bank_result_t r;
		if (bank_ptr >= NUM_BANKS || writes_in_req >= cidrfbp_pkg::MAX_WRITES)
			return cidrfbp_pkg::ST_FULL;
		r = '{cidrfbp_pkg::KIND_BANK, bank_ptr, w1, w2, wide, mmode, cidrfbp_pkg::ST_OK, 1'b0};
		predicted_results.push_back(r);
		writes_in_req++;
		bank_ptr = bank_ptr + 4'd1;
		return cidrfbp_pkg::ST_OK;
	endfunction

	function automatic logic [1:0] close_std_id_bank();
		return emit_bank({std_ids[1], 5'b0, std_ids[0], 5'b0},
			{std_ids[3], 5'b0, std_ids[2], 5'b0}, 1'b0, 1'b0);
	endfunction

	function automatic logic [1:0] close_sm_bank();
		return emit_bank({sm_entries[0][21:11], 5'b0, sm_entries[0][10:0], 5'b0},
			{sm_entries[1][21:11], 5'b0, sm_entries[1][10:0], 5'b0}, 1'b0, 1'b1);
	endfunction

	function automatic logic [1:0] close_ext_id_bank();
		return emit_bank({ext_ids[0], 3'b0}, {ext_ids[1], 3'b0}, 1'b1, 1'b0);
	endfunction

	// partial groups are padded with their first entry
	function automatic logic [1:0] queue_std_id(input logic [10:0] id);
		logic [1:0] st;
		st = cidrfbp_pkg::ST_OK;
		std_ids[2'(std_id_cnt)] = id;
		std_id_cnt++;
		if (std_id_cnt == 1) begin
			std_ids[1] = id;
			std_ids[2] = id;
			std_ids[3] = id;
		end else if (std_id_cnt == 4) begin
			st = close_std_id_bank();
			std_id_cnt = 0;
		end
		return st;
	endfunction

	function automatic logic [1:0] queue_sm_entry(input logic [10:0] id, input logic [10:0] mask);
		logic [1:0] st;
		st = cidrfbp_pkg::ST_OK;
		sm_entries[1'(sm_cnt)] = {mask, id};
		sm_cnt++;
		if (sm_cnt == 1) begin
			sm_entries[1] = {mask, id};
		end else begin
			st = close_sm_bank();
			sm_cnt = 0;
		end
		return st;
	endfunction

	function automatic logic [1:0] queue_ext_id(input logic [28:0] id);
		logic [1:0] st;
		st = cidrfbp_pkg::ST_OK;
		ext_ids[1'(ext_id_cnt)] = id;
		ext_id_cnt++;
		if (ext_id_cnt == 1) begin
			ext_ids[1] = id;
		end else begin
			st = close_ext_id_bank();
			ext_id_cnt = 0;
		end
		return st;
	endfunction

	// log2 of the largest aligned block starting at lo that stays within hi
	function automatic int block_order(input logic [31:0] lo, input logic [31:0] hi, input int bits);
		int k;
		k = 0;
		while (k < bits && !lo[k])
			k++;
		while (k > 0 && {32'b0, lo} + (64'd1 << k) - 64'd1 > {32'b0, hi})
			k--;
		return k;
	endfunction

	function automatic logic [1:0] add_id_range(input logic ext, input logic [28:0] a,
			input logic [28:0] b);
		int          bits;
		int          k;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] maxid;
		logic [31:0] mask;
		logic [1:0]  st;
		bits  = ext ? cidrfbp_pkg::EXT_ID_BITS : cidrfbp_pkg::STD_ID_BITS;
		maxid = (32'd1 << bits) - 32'd1;
		lo    = {3'b0, a};
		hi    = {3'b0, b};
		if (lo > hi) begin
			lo = {3'b0, b};
			hi = {3'b0, a};
		end
		if (hi > maxid)
			return cidrfbp_pkg::ST_RANGE;
		while (lo <= hi) begin
			k    = block_order(lo, hi, bits);
			mask = (32'hFFFF_FFFF << k) & maxid;
			if (mask == maxid) begin
				if (ext)
					st = queue_ext_id(lo[28:0]);
				else
					st = queue_std_id(lo[10:0]);
			end else if (ext) begin
				st = emit_bank({lo[28:0], 3'b0}, {mask[28:0], 3'b0}, 1'b1, 1'b1);
			end else begin
				st = queue_sm_entry(lo[10:0], mask[10:0]);
			end
			if (st != cidrfbp_pkg::ST_OK)
				return st;
			lo = lo + (32'd1 << k);
		end
		return cidrfbp_pkg::ST_OK;
	endfunction

	// flush order: standard list, standard mask, extended list; stop at first failure
	function automatic logic [1:0] flush_partial_banks();
		logic [1:0] st;
		st = cidrfbp_pkg::ST_OK;
		if (std_id_cnt != 0) begin
			st = close_std_id_bank();
			std_id_cnt = 0;
		end
		if (sm_cnt != 0 && st == cidrfbp_pkg::ST_OK) begin
			st = close_sm_bank();
			sm_cnt = 0;
		end
		if (ext_id_cnt != 0 && st == cidrfbp_pkg::ST_OK) begin
			st = close_ext_id_bank();
			ext_id_cnt = 0;
		end
		return st;
	endfunction

	function automatic void predict_request(input logic [1:0] kind, input logic ext,
			input logic [28:0] a, input logic [28:0] b);
		logic [1:0]   st;
		bank_result_t r;
		st = cidrfbp_pkg::ST_OK;
		writes_in_req = 0;
		case (kind)
			cidrfbp_pkg::REQ_ADD:    st = add_id_range(ext, a, b);
			cidrfbp_pkg::REQ_FINISH: st = flush_partial_banks();
			cidrfbp_pkg::REQ_START:  clear_state();
			default:                 st = cidrfbp_pkg::ST_OK;
		endcase
		r = '{cidrfbp_pkg::KIND_STATUS, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0, st, 1'b1};
		predicted_results.push_back(r);
	endfunction

	function automatic void report_mismatch(input string what, input bank_result_t want,
			input bank_result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t %s: expected kind=%0d bank=%0d w1=%h w2=%h wide=%0d mm=%0d st=%0d last=%0d",
				$time, what, want.kind, want.bank, want.word_one, want.word_two,
				want.wide, want.mmode, want.st, want.is_last);
			$display("    got      kind=%0d bank=%0d w1=%h w2=%h wide=%0d mm=%0d st=%0d last=%0d",
				got.kind, got.bank, got.word_one, got.word_two,
				got.wide, got.mmode, got.st, got.is_last);
		end
	endfunction

	function automatic void check_result();
		bank_result_t got;
		bank_result_t want;
		got = '{result_kind, bank_index, filter_word_one, filter_word_two,
			wide_scale, mask_mode, status, last};
		if (predicted_results.size() == 0) begin
			report_mismatch("unexpected transaction", '0, got);
		end else begin
			want = predicted_results.pop_front();
			if (got !== want)
				report_mismatch("result mismatch", want, got);
		end
	endfunction

	initial clear_state();

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				predict_request(req_type, is_extended, range_begin, range_end);
			if (res_valid && res_ready)
				check_result();
			expected_count <= predicted_results.size();
		end
	end

endmodule

>>> sim/can_id_range_filter_bank_packer_core_tb.sv
// Testbench top: stimulus, handshake pacing and verdict for the filter bank packer.
`timescale 1ns / 1ps
module can_id_range_filter_bank_packer_core_tb;

	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	logic [1:0]  req_type;
	logic        is_extended;
	logic [28:0] range_begin;
	logic [28:0] range_end;
	logic        res_valid;
	logic        res_ready;
	logic        result_kind;
	logic [3:0]  bank_index;
	logic [31:0] filter_word_one;
	logic [31:0] filter_word_two;
	logic        wide_scale;
	logic        mask_mode;
	logic [1:0]  status;
	logic        last;
	int          mismatches;
	int          expected_count;
	int          sender_idle_pct;
	int          receiver_stall_pct;

	can_id_range_filter_bank_packer_core i_dut (.*);

	filter_bank_write_checker i_checker (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk)
		res_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);

	task automatic send_request(input logic [1:0] kind, input logic ext,
			input logic [28:0] first_id, input logic [28:0] last_id);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
		end
		req_valid   <= 1'b1;
		req_type    <= kind;
		is_extended <= ext;
		range_begin <= first_id;
		range_end   <= last_id;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic send_random_range();
		logic        ext;
		logic [28:0] a;
		logic [28:0] b;
		logic [28:0] low_bits;
		logic [28:0] t;
		int          pick;
		ext  = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (ext) begin
			a = 29'($urandom());
			if (pick < 25) begin
				b = a;
			end else if (pick < 70) begin
				b = 29'(a + $urandom_range(0, 40));
			end else if (pick < 85) begin
				low_bits = (29'd1 << $urandom_range(1, 12)) - 29'd1;
				a = a & ~low_bits;
				b = a | low_bits;
			end else begin
				b = 29'($urandom());
			end
		end else begin
			a = 29'($urandom_range(0, 2047));
			if (pick < 20)
				b = a;
			else if (pick < 75)
				b = 29'(a + $urandom_range(0, 40));
			else if (pick < 90)
				b = 29'($urandom_range(0, 2047));
			else
				b = 29'($urandom());
		end
		if ($urandom_range(0, 9) < 3) begin
			t = a;
			a = b;
			b = t;
		end
		send_request(cidrfbp_pkg::REQ_ADD, ext, a, b);
	endtask

	// sessions: optional clear, a few ranges, usually a finish, now and then a stray request
	task automatic run_sessions(input int n_items);
		int         sent;
		int         adds;
		logic [1:0] code;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) < 7) begin
				send_request(cidrfbp_pkg::REQ_START, 1'($urandom_range(0, 1)),
					29'($urandom()), 29'($urandom()));
				sent++;
			end
			adds = $urandom_range(1, 7);
			repeat (adds) begin
				send_random_range();
				sent++;
			end
			if ($urandom_range(0, 9) < 8) begin
				send_request(cidrfbp_pkg::REQ_FINISH, 1'($urandom_range(0, 1)),
					29'($urandom()), 29'($urandom()));
				sent++;
			end
			if ($urandom_range(0, 9) == 0) begin
				code = 2'($urandom_range(0, 3));
				send_request(code, 1'($urandom_range(0, 1)), 29'($urandom()), 29'($urandom()));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n             <= 1'b0;
		req_valid          <= 1'b0;
		req_type           <= cidrfbp_pkg::REQ_ADD;
		is_extended        <= 1'b0;
		range_begin        <= '0;
		range_end          <= '0;
		sender_idle_pct    = 21;
		receiver_stall_pct = 83;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(cidrfbp_pkg::REQ_START, 1'b0, 29'd0, 29'd0);
		send_request(cidrfbp_pkg::REQ_ADD, 1'b0, 29'd0, 29'd0);
		send_request(cidrfbp_pkg::REQ_ADD, 1'b0, 29'h7FF, 29'h7F0);
		send_request(cidrfbp_pkg::REQ_ADD, 1'b0, 29'd0, 29'h800);
		send_request(cidrfbp_pkg::REQ_ADD, 1'b0, 29'h1FFF_FFFF, 29'd0);
		send_request(cidrfbp_pkg::REQ_ADD, 1'b1, 29'h1FFF_FFFF, 29'h1FFF_FFFF);
		send_request(cidrfbp_pkg::REQ_ADD, 1'b1, 29'd0, 29'h1FFF_FFFF);
		send_request(cidrfbp_pkg::REQ_ADD, 1'b0, 29'd0, 29'h7FF);
		send_request(cidrfbp_pkg::REQ_ADD, 1'b0, 29'd6, 29'd1);
		send_request(cidrfbp_pkg::REQ_FINISH, 1'b0, 29'd0, 29'd0);
		send_request(cidrfbp_pkg::REQ_FINISH, 1'b1, 29'h1FFF_FFFF, 29'h1FFF_FFFF);
		send_request(REQ_UNUSED, 1'b0, 29'd3, 29'd5);
		send_request(cidrfbp_pkg::REQ_START, 1'b1, 29'h1555_5555, 29'h0AAA_AAAA);
		// runs out of banks part way through
		send_request(cidrfbp_pkg::REQ_ADD, 1'b1, 29'd1, 29'h1FFF_FFFE);
		send_request(cidrfbp_pkg::REQ_FINISH, 1'b0, 29'd0, 29'd0);
		send_request(cidrfbp_pkg::REQ_ADD, 1'b0, 29'd5, 29'd5);
		send_request(cidrfbp_pkg::REQ_FINISH, 1'b0, 29'd0, 29'd0);
		send_request(cidrfbp_pkg::REQ_START, 1'b0, 29'd0, 29'd0);
		send_request(cidrfbp_pkg::REQ_ADD, 1'b0, 29'h555, 29'h2AA);
		send_request(cidrfbp_pkg::REQ_ADD, 1'b1, 29'h0ABC_DEF0, 29'h0ABC_DEFF);
		send_request(cidrfbp_pkg::REQ_ADD, 1'b1, 29'h1234_5678, 29'h1234_567A);
		send_request(cidrfbp_pkg::REQ_FINISH, 1'b0, 29'd0, 29'd0);
		send_request(cidrfbp_pkg::REQ_START, 1'b0, 29'd0, 29'd0);

		run_sessions(50);
		sender_idle_pct    = 83;
		receiver_stall_pct = 21;
		run_sessions(55);
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		run_sessions(55);
		req_valid <= 1'b0;

		@(posedge clk);
		while (expected_count != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && expected_count == 0)
			$display("can_id_range_filter_bank_packer_core regression: pass");
		else
			$display("can_id_range_filter_bank_packer_core regression: fail");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("can_id_range_filter_bank_packer_core regression: fail");
		$finish;
	end

endmodule
